### rtl/spa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package spa_pkg;

   localparam int COEF_W = 16;
   localparam int EXP_W  = 16;
   localparam int SUM_W  = 17;

   typedef enum logic [1:0] {
      OP_LOAD_A = 2'd0,
      OP_LOAD_B = 2'd1,
      OP_RUN    = 2'd2
   } opcode_type;

   // One stored term as it sits in a list memory.
   typedef struct packed {
      logic signed [COEF_W-1:0] coef;
      logic        [EXP_W-1:0]  expo;
   } term_type;

   localparam int TERM_W = $bits(term_type);

   // What the compare/add unit decides for one merge step.
   typedef struct packed {
      logic                    done;
      logic                    take_a;
      logic                    take_b;
      logic                    keep;
      logic signed [SUM_W-1:0] coef;
      logic        [EXP_W-1:0] expo;
   } step_type;

endpackage

`default_nettype wire

### rtl/spa_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface spa_req_if
   import spa_pkg::*;
   ();
   logic                     valid;
   logic                     ready;
   logic [1:0]               opcode;
   logic signed [COEF_W-1:0] coefficient;
   logic [EXP_W-1:0]         exponent;

   modport source (output valid, output opcode, output coefficient, output exponent,
                   input ready);
   modport sink   (input valid, input opcode, input coefficient, input exponent,
                   output ready);
endinterface

interface spa_rsp_if
   import spa_pkg::*;
   ();
   logic                    valid;
   logic                    ready;
   logic signed [SUM_W-1:0] sum_coefficient;
   logic [EXP_W-1:0]        sum_exponent;
   logic                    is_last;
   logic                    is_empty;
   logic                    overflowed;

   modport source (output valid, output sum_coefficient, output sum_exponent,
                   output is_last, output is_empty, output overflowed, input ready);
   modport sink   (input valid, input sum_coefficient, input sum_exponent,
                   input is_last, input is_empty, input overflowed, output ready);
endinterface

`default_nettype wire

### rtl/spa_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module spa_ram #(
   parameter int WIDTH  = 32,
   parameter int DEPTH  = 32,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output      logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/spa_cmpadd.sv
`timescale 1ns / 1ps
`default_nettype none

module spa_cmpadd
   import spa_pkg::*;
(
   input  wire term_type a_term,
   input  wire logic     a_ok,
   input  wire term_type b_term,
   input  wire logic     b_ok,
   output      step_type step
);

   logic signed [SUM_W-1:0] a_ext;
   logic signed [SUM_W-1:0] b_ext;
   logic signed [SUM_W-1:0] sum;

   assign a_ext = SUM_W'(a_term.coef);
   assign b_ext = SUM_W'(b_term.coef);
   assign sum   = a_ext + b_ext;

   always_comb begin
      step = '0;
      if (a_ok && b_ok) begin
         if (a_term.expo > b_term.expo) begin
            step.take_a = 1'b1;
            step.keep   = 1'b1;
            step.coef   = a_ext;
            step.expo   = a_term.expo;
         end else if (a_term.expo < b_term.expo) begin
            step.take_b = 1'b1;
            step.keep   = 1'b1;
            step.coef   = b_ext;
            step.expo   = b_term.expo;
         end else begin
            // equal exponents: add, drop the term when it cancels
            step.take_a = 1'b1;
            step.take_b = 1'b1;
            step.keep   = (sum != '0);
            step.coef   = sum;
            step.expo   = a_term.expo;
         end
      end else if (a_ok) begin
         step.take_a = 1'b1;
         step.keep   = 1'b1;
         step.coef   = a_ext;
         step.expo   = a_term.expo;
      end else if (b_ok) begin
         step.take_b = 1'b1;
         step.keep   = 1'b1;
         step.coef   = b_ext;
         step.expo   = b_term.expo;
      end else begin
         step.done = 1'b1;
      end
   end

endmodule

`default_nettype wire

### rtl/sparse_polynomial_adder_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Load word: accepted while idle, no response word.
// Run word: each merge step reads the list memories (S_READ), then compares and adds
//    (S_CMP); every emitted word waits in S_DRAIN until rsp ready is seen.
// The next request word is taken once the last word of a run has been delivered.
// Synchronous reset clears the list counts, the overflow flag and the sequencer.
module sparse_polynomial_adder_unit
   import spa_pkg::*;
#(
   parameter int TERM_DEPTH = 32
) (
   input wire logic clock,
   input wire logic reset,
   spa_req_if.sink   req_bus,
   spa_rsp_if.source rsp_bus
);

   localparam int CNT_W  = $clog2(TERM_DEPTH + 1);
   localparam int ADDR_W = (TERM_DEPTH > 1) ? $clog2(TERM_DEPTH) : 1;

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_READ  = 4'b0010,
      S_CMP   = 4'b0100,
      S_DRAIN = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   logic [CNT_W-1:0] count_a_ff, count_a_in;
   logic [CNT_W-1:0] count_b_ff, count_b_in;
   logic [CNT_W-1:0] ia_ff, ia_in;
   logic [CNT_W-1:0] ib_ff, ib_in;
   logic             ovf_ff, ovf_in;
   logic             final_ff, final_in;

   // held term: emitted only once we know whether it is the last one
   logic                    pend_valid_ff, pend_valid_in;
   logic signed [SUM_W-1:0] pend_coef_ff, pend_coef_in;
   logic [EXP_W-1:0]        pend_expo_ff, pend_expo_in;

   // response word register
   logic signed [SUM_W-1:0] out_coef_ff, out_coef_in;
   logic [EXP_W-1:0]        out_expo_ff, out_expo_in;
   logic                    out_last_ff, out_last_in;
   logic                    out_empty_ff, out_empty_in;

   logic       req_fire;
   logic       wr_a, wr_b;
   term_type   wr_term;
   term_type   a_term, b_term;
   logic       a_ok, b_ok;
   step_type   step;
   opcode_type req_op;

   assign req_op   = opcode_type'(req_bus.opcode);
   assign req_fire = req_bus.valid && req_bus.ready;

   assign wr_term.coef = req_bus.coefficient;
   assign wr_term.expo = req_bus.exponent;
   assign wr_a = req_fire && (req_op == OP_LOAD_A) && (count_a_ff < CNT_W'(TERM_DEPTH));
   assign wr_b = req_fire && (req_op == OP_LOAD_B) && (count_b_ff < CNT_W'(TERM_DEPTH));

   spa_ram #(
      .WIDTH (TERM_W),
      .DEPTH (TERM_DEPTH),
      .ADDR_W(ADDR_W)
   ) u_ram_a (
      .clock  (clock),
      .wr_en  (wr_a),
      .wr_addr(count_a_ff[ADDR_W-1:0]),
      .wr_data(wr_term),
      .rd_addr(ia_ff[ADDR_W-1:0]),
      .rd_data(a_term)
   );

   spa_ram #(
      .WIDTH (TERM_W),
      .DEPTH (TERM_DEPTH),
      .ADDR_W(ADDR_W)
   ) u_ram_b (
      .clock  (clock),
      .wr_en  (wr_b),
      .wr_addr(count_b_ff[ADDR_W-1:0]),
      .wr_data(wr_term),
      .rd_addr(ib_ff[ADDR_W-1:0]),
      .rd_data(b_term)
   );

   assign a_ok = (ia_ff < count_a_ff);
   assign b_ok = (ib_ff < count_b_ff);

   spa_cmpadd u_cmpadd (
      .a_term(a_term),
      .a_ok  (a_ok),
      .b_term(b_term),
      .b_ok  (b_ok),
      .step  (step)
   );

   always_comb begin
      state_in      = state_ff;
      count_a_in    = count_a_ff;
      count_b_in    = count_b_ff;
      ia_in         = ia_ff;
      ib_in         = ib_ff;
      ovf_in        = ovf_ff;
      final_in      = final_ff;
      pend_valid_in = pend_valid_ff;
      pend_coef_in  = pend_coef_ff;
      pend_expo_in  = pend_expo_ff;
      out_coef_in   = out_coef_ff;
      out_expo_in   = out_expo_ff;
      out_last_in   = out_last_ff;
      out_empty_in  = out_empty_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               unique case (req_op)
                  OP_LOAD_A: begin
                     // append, or drop and flag when the list is full
                     if (wr_a) begin
                        count_a_in = count_a_ff + CNT_W'(1);
                     end else begin
                        ovf_in = 1'b1;
                     end
                  end
                  OP_LOAD_B: begin
                     if (wr_b) begin
                        count_b_in = count_b_ff + CNT_W'(1);
                     end else begin
                        ovf_in = 1'b1;
                     end
                  end
                  OP_RUN: begin
                     ia_in         = '0;
                     ib_in         = '0;
                     pend_valid_in = 1'b0;
                     state_in      = S_READ;
                  end
                  default: begin
                     // unused opcode: ignore
                  end
               endcase
            end
         end
         S_READ: begin
            // list memories are addressed by ia/ib; data lands next cycle
            state_in = S_CMP;
         end
         S_CMP: begin
            ia_in = ia_ff + CNT_W'(step.take_a);
            ib_in = ib_ff + CNT_W'(step.take_b);
            if (step.done) begin
               final_in = 1'b1;
               if (pend_valid_ff) begin
                  out_coef_in  = pend_coef_ff;
                  out_expo_in  = pend_expo_ff;
                  out_empty_in = 1'b0;
               end else begin
                  out_coef_in  = '0;
                  out_expo_in  = '0;
                  out_empty_in = 1'b1;
               end
               out_last_in = 1'b1;
               state_in    = S_DRAIN;
            end else if (step.keep) begin
               pend_valid_in = 1'b1;
               pend_coef_in  = step.coef;
               pend_expo_in  = step.expo;
               if (pend_valid_ff) begin
                  // a newer term exists, so the held one is not last
                  out_coef_in  = pend_coef_ff;
                  out_expo_in  = pend_expo_ff;
                  out_last_in  = 1'b0;
                  out_empty_in = 1'b0;
                  final_in     = 1'b0;
                  state_in     = S_DRAIN;
               end else begin
                  state_in = S_READ;
               end
            end else begin
               state_in = S_READ;
            end
         end
         S_DRAIN: begin
            if (rsp_bus.ready) begin
               if (final_ff) begin
                  // run complete: drop both lists and the flag
                  count_a_in = '0;
                  count_b_in = '0;
                  ovf_in     = 1'b0;
                  state_in   = S_IDLE;
               end else begin
                  state_in = S_READ;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_a_ff    <= '0;
         count_b_ff    <= '0;
         ovf_ff        <= 1'b0;
         final_ff      <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_a_ff    <= count_a_in;
         count_b_ff    <= count_b_in;
         ovf_ff        <= ovf_in;
         final_ff      <= final_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ia_ff        <= ia_in;
      ib_ff        <= ib_in;
      pend_coef_ff <= pend_coef_in;
      pend_expo_ff <= pend_expo_in;
      out_coef_ff  <= out_coef_in;
      out_expo_ff  <= out_expo_in;
      out_last_ff  <= out_last_in;
      out_empty_ff <= out_empty_in;
   end

   assign req_bus.ready = (state_ff == S_IDLE);

   assign rsp_bus.valid           = (state_ff == S_DRAIN);
   assign rsp_bus.sum_coefficient = out_coef_ff;
   assign rsp_bus.sum_exponent    = out_expo_ff;
   assign rsp_bus.is_last         = out_last_ff;
   assign rsp_bus.is_empty        = out_empty_ff;
   assign rsp_bus.overflowed      = ovf_ff;

   // no request is taken while a response word is waiting
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      req_bus.ready |-> !rsp_bus.valid)
      else $error("request accepted while response pending");

   // an empty sum is always the only, hence last, word of its run
   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.is_empty) |-> rsp_bus.is_last)
      else $error("empty word not marked last");

   // delivering the last word clears both lists and the flag
   a_run_clears: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.ready && rsp_bus.is_last) |=>
         (count_a_ff == '0 && count_b_ff == '0 && !ovf_ff && req_bus.ready))
      else $error("run end did not clear state");

   // list fill never passes the memory depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (count_a_ff <= CNT_W'(TERM_DEPTH)) && (count_b_ff <= CNT_W'(TERM_DEPTH)))
      else $error("list count beyond depth");

endmodule

`default_nettype wire

### bench/sparse_polynomial_adder_checker.sv
`timescale 1ns / 1ps

module sparse_polynomial_adder_checker
   import spa_pkg::*;
#(
   parameter int TERM_DEPTH = 32
) (
   input wire logic clock,
   input wire logic reset,
   spa_req_if       req_bus,
   spa_rsp_if       rsp_bus,
   output int       fail_count,
   output int       pending
);

   typedef struct packed {
      logic signed [SUM_W-1:0] coef;
      logic        [EXP_W-1:0] expo;
      logic                    last;
      logic                    empty;
      logic                    ovf;
   } sum_term_type;

   logic signed [COEF_W-1:0] a_coef [TERM_DEPTH];
   logic        [EXP_W-1:0]  a_expo [TERM_DEPTH];
   logic signed [COEF_W-1:0] b_coef [TERM_DEPTH];
   logic        [EXP_W-1:0]  b_expo [TERM_DEPTH];
   int                       a_count;
   int                       b_count;
   logic                     dropped;
   sum_term_type             expected_terms [$];
   sum_term_type             want;

   initial begin
      fail_count = 0;
      pending    = 0;
   end

   function automatic logic signed [SUM_W-1:0] widen(input logic signed [COEF_W-1:0] c);
      return {c[COEF_W-1], c};
   endfunction

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t ns: %s", $time, msg);
      fail_count++;
   endtask

   // Merge both lists by exponent, queue the sum words, clear the lists.
   task automatic add_lists();
      sum_term_type            run_terms [$];
      sum_term_type            t;
      logic signed [SUM_W-1:0] s;
      int                      ia;
      int                      ib;
      ia    = 0;
      ib    = 0;
      t     = '0;
      t.ovf = dropped;
      while (ia < a_count && ib < b_count) begin
         if (a_expo[ia] > b_expo[ib]) begin
            t.coef = widen(a_coef[ia]);
            t.expo = a_expo[ia];
            run_terms.push_back(t);
            ia++;
         end else if (a_expo[ia] < b_expo[ib]) begin
            t.coef = widen(b_coef[ib]);
            t.expo = b_expo[ib];
            run_terms.push_back(t);
            ib++;
         end else begin
            s = widen(a_coef[ia]) + widen(b_coef[ib]);
            if (s != 0) begin
               t.coef = s;
               t.expo = a_expo[ia];
               run_terms.push_back(t);
            end
            ia++;
            ib++;
         end
      end
      for (; ia < a_count; ia++) begin
         t.coef = widen(a_coef[ia]);
         t.expo = a_expo[ia];
         run_terms.push_back(t);
      end
      for (; ib < b_count; ib++) begin
         t.coef = widen(b_coef[ib]);
         t.expo = b_expo[ib];
         run_terms.push_back(t);
      end
      if (run_terms.size() == 0) begin
         t.coef  = '0;
         t.expo  = '0;
         t.empty = 1'b1;
      end else begin
         t = run_terms.pop_back();
      end
      t.last = 1'b1;
      run_terms.push_back(t);
      foreach (run_terms[i]) expected_terms.push_back(run_terms[i]);
      a_count = 0;
      b_count = 0;
      dropped = 1'b0;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         a_count = 0;
         b_count = 0;
         dropped = 1'b0;
         expected_terms.delete();
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_terms.size() == 0) begin
               report_mismatch($sformatf("sum word with none expected: coef %0d expo %0d",
                                         rsp_bus.sum_coefficient, rsp_bus.sum_exponent));
            end else begin
               want = expected_terms.pop_front();
               if (rsp_bus.sum_coefficient !== want.coef)
                  report_mismatch($sformatf("sum_coefficient %0d, want %0d",
                                            rsp_bus.sum_coefficient, want.coef));
               if (rsp_bus.sum_exponent !== want.expo)
                  report_mismatch($sformatf("sum_exponent %0d, want %0d",
                                            rsp_bus.sum_exponent, want.expo));
               if (rsp_bus.is_last !== want.last)
                  report_mismatch($sformatf("is_last %b, want %b", rsp_bus.is_last, want.last));
               if (rsp_bus.is_empty !== want.empty)
                  report_mismatch($sformatf("is_empty %b, want %b",
                                            rsp_bus.is_empty, want.empty));
               if (rsp_bus.overflowed !== want.ovf)
                  report_mismatch($sformatf("overflowed %b, want %b",
                                            rsp_bus.overflowed, want.ovf));
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            case (req_bus.opcode)
               OP_LOAD_A: begin
                  if (a_count < TERM_DEPTH) begin
                     a_coef[a_count] = req_bus.coefficient;
                     a_expo[a_count] = req_bus.exponent;
                     a_count++;
                  end else begin
                     dropped = 1'b1;
                  end
               end
               OP_LOAD_B: begin
                  if (b_count < TERM_DEPTH) begin
                     b_coef[b_count] = req_bus.coefficient;
                     b_expo[b_count] = req_bus.exponent;
                     b_count++;
                  end else begin
                     dropped = 1'b1;
                  end
               end
               OP_RUN: add_lists();
               default: ;
            endcase
         end
      end
      pending = expected_terms.size();
   end

endmodule

### bench/sparse_polynomial_adder_unit_tb.sv
`timescale 1ns / 1ps

module sparse_polynomial_adder_unit_tb;
   import spa_pkg::*;

   localparam int         TERM_DEPTH    = 32;
   localparam int         RANDOM_WORDS  = 150;
   localparam int         MAX_WAIT      = 6;
   localparam int         SETTLE_CYCLES = 20;
   // Worst run merges 2*32 terms, each word possibly stalled by the result side.
   localparam int         CYCLE_LIMIT   = 400000;
   localparam logic [1:0] OP_UNUSED     = 2'd3;

   logic clock = 1'b0;
   logic reset;
   int   fail_count;
   int   pending;
   int   cycle_count;
   int   req_steady = 0;
   int   rsp_steady = 0;
   int   words_sent;

   spa_req_if req_bus ();
   spa_rsp_if rsp_bus ();

   sparse_polynomial_adder_unit #(
      .TERM_DEPTH(TERM_DEPTH)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus)
   );

   sparse_polynomial_adder_checker #(
      .TERM_DEPTH(TERM_DEPTH)
   ) checker_inst (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .fail_count(fail_count),
      .pending   (pending)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Draw the idle cycles before the next word; now and then hold a calm
   // stretch with no idling at all.
   task automatic draw_wait(inout int steady, output int cycles);
      if (steady > 0) begin
         steady--;
         cycles = 0;
      end else if ($urandom_range(0, 15) == 0) begin
         steady = $urandom_range(4, 24);
         cycles = 0;
      end else begin
         cycles = $urandom_range(0, MAX_WAIT);
      end
   endtask

   // Drive one request word and hold it until the block takes it.
   task automatic send_word(input logic [1:0] op, input logic [COEF_W-1:0] coef,
                            input logic [EXP_W-1:0] expo);
      int gap;
      draw_wait(req_steady, gap);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.opcode      <= op;
      req_bus.coefficient <= coef;
      req_bus.exponent    <= expo;
      do @(posedge clock); while (!req_bus.ready);
      if (op != OP_UNUSED) words_sent++;
   endtask

   // Build two lists in descending exponent order, share some exponents
   // (a few of them cancelling), interleave the loads, then run the merge.
   // Sizes above TERM_DEPTH push the extra terms into the dropped path.
   task automatic send_pair(input int na, input int nb, input int share_pct);
      logic [COEF_W-1:0] a_c [$];
      logic [EXP_W-1:0]  a_e [$];
      logic [COEF_W-1:0] b_c [$];
      logic [EXP_W-1:0]  b_e [$];
      logic [COEF_W-1:0] c;
      int                need_a;
      int                need_b;
      int                left;
      int                expo;
      int                span;
      int                ia;
      int                ib;
      need_a = na;
      need_b = nb;
      left   = na + nb;
      expo   = $urandom_range(65535, left);
      while (need_a > 0 || need_b > 0) begin
         c = COEF_W'($urandom);
         if (need_a > 0 && need_b > 0 && $urandom_range(0, 99) < share_pct) begin
            a_c.push_back(c);
            a_e.push_back(EXP_W'(expo));
            b_c.push_back(($urandom_range(0, 2) == 0) ? -c : COEF_W'($urandom));
            b_e.push_back(EXP_W'(expo));
            need_a--;
            need_b--;
         end else if (need_a > 0 && (need_b == 0 || $urandom_range(0, 1))) begin
            a_c.push_back(c);
            a_e.push_back(EXP_W'(expo));
            need_a--;
         end else begin
            b_c.push_back(c);
            b_e.push_back(EXP_W'(expo));
            need_b--;
         end
         // Step down, keeping room for every exponent still to come.
         left = need_a + need_b;
         if (left > 0) begin
            span = expo - left;
            expo = expo - 1 - $urandom_range(0, (span > 999) ? 999 : span);
         end
      end
      ia = 0;
      ib = 0;
      while (ia < a_c.size() || ib < b_c.size()) begin
         if (ia < a_c.size() && (ib >= b_c.size() || $urandom_range(0, 1))) begin
            send_word(OP_LOAD_A, a_c[ia], a_e[ia]);
            ia++;
         end else begin
            send_word(OP_LOAD_B, b_c[ib], b_e[ib]);
            ib++;
         end
      end
      send_word(OP_RUN, COEF_W'($urandom), EXP_W'($urandom));
   endtask

   // Mostly short lists, now and then a long one.
   function automatic int list_size();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(12, TERM_DEPTH) : $urandom_range(0, 6);
   endfunction

   // Hold the result side: stall a random number of cycles before each word.
   initial begin
      int stall;
      rsp_bus.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         draw_wait(rsp_steady, stall);
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
      end
   end

   // Give up when the run takes far longer than any correct block would.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      reset               <= 1'b1;
      req_bus.valid       <= 1'b0;
      req_bus.opcode      <= OP_LOAD_A;
      req_bus.coefficient <= '0;
      req_bus.exponent    <= '0;
      words_sent          = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Run on two empty lists: expect a single empty word.
      send_word(OP_RUN, COEF_W'($urandom), EXP_W'($urandom));

      // Field extremes: largest and most negative sums at the top and bottom exponents.
      send_word(OP_LOAD_A, 16'sh7fff, 16'hffff);
      send_word(OP_LOAD_A, 16'sh8000, 16'h0000);
      send_word(OP_LOAD_B, 16'sh7fff, 16'hffff);
      send_word(OP_LOAD_B, 16'sh8000, 16'h0000);
      send_word(OP_RUN, COEF_W'($urandom), EXP_W'($urandom));

      // Equal exponents that cancel: the sum has no terms left.
      send_word(OP_LOAD_A, 16'sd5, 16'd10);
      send_word(OP_LOAD_B, -16'sd5, 16'd10);
      send_word(OP_RUN, COEF_W'($urandom), EXP_W'($urandom));

      // One list alone, then the other alone.
      send_word(OP_LOAD_A, 16'sd1, 16'd3);
      send_word(OP_RUN, COEF_W'($urandom), EXP_W'($urandom));
      send_word(OP_LOAD_B, -16'sd1, 16'd7);
      send_word(OP_RUN, COEF_W'($urandom), EXP_W'($urandom));

      // Unsorted list A: the merge compares heads as they come.
      send_word(OP_LOAD_A, 16'sd1, 16'd2);
      send_word(OP_LOAD_A, 16'sd1, 16'd9);
      send_word(OP_LOAD_B, 16'sd1, 16'd5);
      send_word(OP_RUN, COEF_W'($urandom), EXP_W'($urandom));

      // Unused opcode between a load and a run must leave the list alone.
      send_word(OP_LOAD_A, 16'sd7, 16'd1);
      send_word(OP_UNUSED, 16'hffff, 16'hffff);
      send_word(OP_RUN, COEF_W'($urandom), EXP_W'($urandom));

      // Overfill both lists with distinct exponents: widest run, flag set.
      send_pair(TERM_DEPTH + 1, TERM_DEPTH + 1, 0);

      while (words_sent < RANDOM_WORDS) begin
         case ($urandom_range(0, 9))
            0, 1: begin
               // Noise: any opcode, any fields, possibly no run at the end.
               repeat ($urandom_range(1, 6))
                  send_word(2'($urandom_range(0, 3)), COEF_W'($urandom),
                            EXP_W'($urandom));
            end
            2: begin
               if ($urandom_range(0, 1))
                  send_pair(TERM_DEPTH + $urandom_range(0, 2), $urandom_range(0, 4), 20);
               else
                  send_pair($urandom_range(0, 4), TERM_DEPTH + $urandom_range(0, 2), 20);
            end
            default: send_pair(list_size(), list_size(), $urandom_range(0, 100));
         endcase
      end
      req_bus.valid <= 1'b0;

      // Drain every expected word, then watch for strays.
      @(posedge clock);
      wait (pending == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

### files.f
rtl/spa_pkg.sv
rtl/spa_if.sv
rtl/spa_ram.sv
rtl/spa_cmpadd.sv
rtl/sparse_polynomial_adder_unit.sv
bench/sparse_polynomial_adder_checker.sv
bench/sparse_polynomial_adder_unit_tb.sv
